>>> src/apf_pkg.sv
// apf_pkg: field widths, codes and limits shared by the articulation point finder
// depends on nothing
package apf_pkg;

   localparam int VC_W         = 7;
   localparam logic [VC_W-1:0] VC_RESET = 7'd64;
   localparam int EP_W         = 6;
   localparam int CV_W         = 6;
   localparam int RESULT_LIMIT = 64;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 8;

   typedef enum logic {
      MODE_EDGE = 1'b0,
      MODE_RUN  = 1'b1
   } mode_type;

endpackage

>>> src/apf_ram.sv
// apf_ram: generic single write port, single read port ram with registered read
// depends on nothing
module apf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/apf_walk.sv
// apf_walk: edge loading into the adjacency ram and the depth-first walk sequencer
// depends on apf_pkg and apf_ram
module apf_walk #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  apf_pkg::mode_type                    in_mode,
   input  logic [apf_pkg::EP_W-1:0]             in_a,
   input  logic [apf_pkg::EP_W-1:0]             in_b,
   input  logic [apf_pkg::VC_W-1:0]             vertex_count,
   output logic                                 emit_go,
   input  logic                                 emit_done,
   output logic [$clog2(MAX_VERTICES+1)-1:0]    n_out,
   output logic [MAX_VERTICES-1:0]              cut_out
);
   import apf_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int DW = $clog2(MAX_VERTICES + 2);
   localparam int SW = VW + CW + VW + DW + DW;
   localparam int O_LOW = DW;
   localparam int O_PAR = 2 * DW;
   localparam int O_CUR = 2 * DW + VW;
   localparam int O_V   = 2 * DW + VW + CW;

   typedef enum logic [3:0] {
      W_IDLE, W_EDGE_WA, W_EDGE_WB, W_LOAD, W_ROW, W_SCAN, W_BACK, W_POP1, W_POP2, W_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in;
   logic [CW-1:0] n_ff, n_in;
   logic [VW-1:0] cur_v_ff, cur_v_in, cur_par_ff, cur_par_in;
   logic [CW-1:0] cur_w_ff, cur_w_in;
   logic [DW-1:0] cur_low_ff, cur_low_in, cur_disc_ff, cur_disc_in;
   logic [DW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [1:0]    rc_ff, rc_in;
   logic [MAX_VERTICES-1:0] row_ff, row_in, vis_ff, vis_in, cut_ff, cut_in, rv_ff, rv_in;
   logic          rok_ff, rok_in;

   logic                    adj_we;
   logic [VW-1:0]           adj_wa, adj_ra;
   logic [MAX_VERTICES-1:0] adj_wd, adj_rd, adj_row;
   logic                    disc_we;
   logic [VW-1:0]           disc_wa, disc_ra;
   logic [DW-1:0]           disc_wd, disc_rd;
   logic                    st_we;
   logic [VW-1:0]           st_wa, st_ra;
   logic [SW-1:0]           st_wd, st_rd;
   logic [VW-1:0]           w_idx, p_v;
   logic [DW-1:0]           p_low, p_disc;
   logic                    in_range;

   apf_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
      .clock(clock), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
      .raddr(adj_ra), .rdata(adj_rd)
   );
   apf_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_disc (
      .clock(clock), .we(disc_we), .waddr(disc_wa), .wdata(disc_wd),
      .raddr(disc_ra), .rdata(disc_rd)
   );
   apf_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
      .clock(clock), .we(st_we), .waddr(st_wa), .wdata(st_wd),
      .raddr(st_ra), .rdata(st_rd)
   );

   // rows never written read as zero
   assign adj_row  = adj_rd & {MAX_VERTICES{rok_ff}};
   assign w_idx    = cur_w_ff[VW-1:0];
   assign p_v      = st_rd[O_V +: VW];
   assign p_low    = st_rd[O_LOW +: DW];
   assign p_disc   = st_rd[DW-1:0];
   assign in_range = (32'(in_a) < MAX_VERTICES) && (32'(in_b) < MAX_VERTICES);

   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      n_in        = n_ff;
      cur_v_in    = cur_v_ff;
      cur_w_in    = cur_w_ff;
      cur_par_in  = cur_par_ff;
      cur_low_in  = cur_low_ff;
      cur_disc_in = cur_disc_ff;
      cnt_in      = cnt_ff;
      sp_in       = sp_ff;
      rc_in       = rc_ff;
      row_in      = row_ff;
      vis_in      = vis_ff;
      cut_in      = cut_ff;
      rv_in       = rv_ff;
      adj_we      = 1'b0;
      adj_wa      = a_ff;
      adj_wd      = adj_row;
      adj_ra      = cur_v_ff;
      disc_we     = 1'b0;
      disc_wa     = w_idx;
      disc_wd     = cnt_ff;
      disc_ra     = w_idx;
      st_we       = 1'b0;
      st_wa       = sp_ff[VW-1:0];
      st_wd       = {cur_v_ff, cur_w_ff + CW'(1), cur_par_ff, cur_low_ff, cur_disc_ff};
      st_ra       = VW'(sp_ff - CW'(1));
      emit_go     = 1'b0;

      case (state_ff)
         W_IDLE: begin
            adj_ra = VW'(in_a);
            if (in_valid) begin
               if (in_mode == MODE_RUN) begin
                  if (vertex_count == '0) begin
                     n_in = CW'(1);
                  end else if (32'(vertex_count) > MAX_VERTICES) begin
                     n_in = CW'(MAX_VERTICES);
                  end else begin
                     n_in = CW'(vertex_count);
                  end
                  cut_in      = '0;
                  vis_in      = MAX_VERTICES'(1);
                  cnt_in      = DW'(2);
                  cur_v_in    = '0;
                  cur_w_in    = '0;
                  cur_par_in  = '0;
                  cur_low_in  = DW'(1);
                  cur_disc_in = DW'(1);
                  sp_in       = '0;
                  rc_in       = '0;
                  disc_we     = 1'b1;
                  disc_wa     = '0;
                  disc_wd     = DW'(1);
                  state_in    = W_LOAD;
               end else if (in_range) begin
                  a_in     = VW'(in_a);
                  b_in     = VW'(in_b);
                  state_in = W_EDGE_WA;
               end
            end
         end
         W_EDGE_WA: begin
            adj_we       = 1'b1;
            adj_wa       = a_ff;
            adj_wd       = adj_row | (MAX_VERTICES'(1) << b_ff);
            rv_in[a_ff]  = 1'b1;
            adj_ra       = b_ff;
            state_in     = W_EDGE_WB;
         end
         W_EDGE_WB: begin
            adj_we       = 1'b1;
            adj_wa       = b_ff;
            adj_wd       = adj_row | (MAX_VERTICES'(1) << a_ff);
            rv_in[b_ff]  = 1'b1;
            state_in     = W_IDLE;
         end
         W_LOAD: begin
            state_in = W_ROW;
         end
         W_ROW: begin
            row_in   = adj_row;
            state_in = W_SCAN;
         end
         W_SCAN: begin
            if (cur_w_ff >= n_ff) begin
               state_in = W_POP1;
            end else begin
               cur_w_in = cur_w_ff + CW'(1);
               if (row_ff[w_idx] && (w_idx != cur_v_ff)) begin
                  if (!vis_ff[w_idx]) begin
                     // tree edge: suspend the current frame on the stack
                     st_we         = 1'b1;
                     disc_we       = 1'b1;
                     vis_in[w_idx] = 1'b1;
                     if ((cur_v_ff == '0) && (rc_ff != 2'd2)) begin
                        rc_in = rc_ff + 2'd1;
                     end
                     cur_v_in    = w_idx;
                     cur_w_in    = '0;
                     cur_par_in  = cur_v_ff;
                     cur_low_in  = cnt_ff;
                     cur_disc_in = cnt_ff;
                     cnt_in      = cnt_ff + DW'(1);
                     sp_in       = sp_ff + CW'(1);
                     state_in    = W_LOAD;
                  end else if ((cur_v_ff == '0) || (w_idx != cur_par_ff)) begin
                     state_in = W_BACK;
                  end
               end
            end
         end
         W_BACK: begin
            if (disc_rd < cur_low_ff) begin
               cur_low_in = disc_rd;
            end
            state_in = W_SCAN;
         end
         W_POP1: begin
            if (sp_ff == '0) begin
               if (rc_ff == 2'd2) begin
                  cut_in[0] = 1'b1;
               end
               emit_go  = 1'b1;
               state_in = W_EMIT;
            end else begin
               state_in = W_POP2;
            end
         end
         W_POP2: begin
            cur_v_in    = p_v;
            cur_w_in    = st_rd[O_CUR +: CW];
            cur_par_in  = st_rd[O_PAR +: VW];
            cur_disc_in = p_disc;
            cur_low_in  = (cur_low_ff < p_low) ? cur_low_ff : p_low;
            if ((p_v != '0) && (p_disc <= cur_low_ff)) begin
               cut_in[p_v] = 1'b1;
            end
            sp_in    = sp_ff - CW'(1);
            state_in = W_LOAD;
         end
         W_EMIT: begin
            if (emit_done) begin
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
      rok_in = rv_ff[adj_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         rv_ff    <= '0;
         vis_ff   <= '0;
         cut_ff   <= '0;
         cnt_ff   <= DW'(1);
         sp_ff    <= '0;
         rc_ff    <= '0;
         n_ff     <= CW'(1);
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         vis_ff   <= vis_in;
         cut_ff   <= cut_in;
         cnt_ff   <= cnt_in;
         sp_ff    <= sp_in;
         rc_ff    <= rc_in;
         n_ff     <= n_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      cur_v_ff    <= cur_v_in;
      cur_w_ff    <= cur_w_in;
      cur_par_ff  <= cur_par_in;
      cur_low_ff  <= cur_low_in;
      cur_disc_ff <= cur_disc_in;
      row_ff      <= row_in;
      rok_ff      <= rok_in;
   end

   assign in_ready = (state_ff == W_IDLE);
   assign n_out    = n_ff;
   assign cut_out  = cut_ff;

endmodule

>>> src/apf_emit.sv
// apf_emit: scans the cut marks in ascending order and drives the result register
// depends on apf_pkg
module apf_emit #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] n_in,
   input  logic [MAX_VERTICES-1:0]           cut,
   output logic                              done,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [apf_pkg::CV_W-1:0]          rsp_vertex,
   output logic                              rsp_found,
   output logic                              rsp_last
);
   import apf_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int KW = $clog2(RESULT_LIMIT + 1);

   typedef enum logic {E_IDLE, E_SCAN} state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   e_ff, e_in;
   logic [VW-1:0]   hold_ff, hold_in;
   logic            hok_ff, hok_in;
   logic [KW-1:0]   cnt_ff, cnt_in;
   logic            valid_ff, valid_in;
   logic [CV_W-1:0] vert_ff, vert_in;
   logic            found_ff, found_in, last_ff, last_in;
   logic            done_ff, done_in;
   logic            free;
   logic [VW-1:0]   e_idx;

   assign free  = !valid_ff || rsp_ready;
   assign e_idx = e_ff[VW-1:0];

   always_comb begin
      state_in = state_ff;
      e_in     = e_ff;
      hold_in  = hold_ff;
      hok_in   = hok_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_ready;
      vert_in  = vert_ff;
      found_in = found_ff;
      last_in  = last_ff;
      done_in  = 1'b0;
      case (state_ff)
         E_IDLE: begin
            if (go) begin
               e_in     = '0;
               hok_in   = 1'b0;
               cnt_in   = '0;
               state_in = E_SCAN;
            end
         end
         E_SCAN: begin
            if (e_ff < n_in) begin
               if (cut[e_idx]) begin
                  if (hok_ff) begin
                     // a later cut vertex exists, so the held one is last only if it reaches the result limit
                     if (free) begin
                        valid_in = 1'b1;
                        vert_in  = CV_W'(hold_ff);
                        found_in = 1'b1;
                        last_in  = (cnt_ff == KW'(RESULT_LIMIT - 1));
                        cnt_in   = cnt_ff + KW'(1);
                        if (cnt_ff == KW'(RESULT_LIMIT - 1)) begin
                           done_in  = 1'b1;
                           state_in = E_IDLE;
                        end else begin
                           hold_in = e_idx;
                           e_in    = e_ff + CW'(1);
                        end
                     end
                  end else begin
                     hold_in = e_idx;
                     hok_in  = 1'b1;
                     e_in    = e_ff + CW'(1);
                  end
               end else begin
                  e_in = e_ff + CW'(1);
               end
            end else if (free) begin
               valid_in = 1'b1;
               vert_in  = hok_ff ? CV_W'(hold_ff) : '0;
               found_in = hok_ff;
               last_in  = 1'b1;
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
      e_ff     <= e_in;
      hold_ff  <= hold_in;
      hok_ff   <= hok_in;
      cnt_ff   <= cnt_in;
      vert_ff  <= vert_in;
      found_ff <= found_in;
      last_ff  <= last_in;
   end

   assign done       = done_ff;
   assign rsp_valid  = valid_ff;
   assign rsp_vertex = vert_ff;
   assign rsp_found  = found_ff;
   assign rsp_last   = last_ff;

endmodule

>>> src/articulation_point_finder_unit.sv
// articulation_point_finder_unit: top level of the cut vertex finder
// depends on apf_pkg, apf_walk, apf_emit
//
//   channel  direction  contents
//   req_     in         tuser mode, tdata end_a/end_b
//   rsp_     out        tdata cut_vertex, tuser found, tlast last
//   csr_     in         vertex_count write
//
// an edge item does a read-modify-write of both adjacency rows, one after the other
// a run item walks depth-first from vertex 0: it loads each row into the scan
// register, scans every vertex index in a row, reads the discovery number on each back
// edge and restores a frame on each stack pop, then scans the cut marks; result stalls hold that scan
// synchronous reset clears adjacency row valid bits at once, no clearing pass
// req_tready stays low while an item is in progress
module articulation_point_finder_unit #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [apf_pkg::REQ_DATA_W-1:0] req_tdata,  // end_a[5:0], end_b[11:6]
   input  logic                           req_tuser,  // mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [apf_pkg::RSP_DATA_W-1:0] rsp_tdata,  // cut_vertex[5:0]
   output logic                           rsp_tuser,  // found
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [apf_pkg::VC_W-1:0]       csr_wdata
);
   import apf_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);

   logic [VC_W-1:0]         vc_ff, vc_in;
   logic                    emit_go, emit_done;
   logic [CW-1:0]           n_cur;
   logic [MAX_VERTICES-1:0] cut;
   logic [CV_W-1:0]         rsp_vertex;
   mode_type                req_mode;

   assign vc_in    = csr_we ? csr_wdata : vc_ff;
   assign req_mode = mode_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= VC_RESET;
      end else begin
         vc_ff <= vc_in;
      end
   end

   apf_walk #(.MAX_VERTICES(MAX_VERTICES)) u_walk (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_mode      (req_mode),
      .in_a         (req_tdata[EP_W-1:0]),
      .in_b         (req_tdata[2*EP_W-1:EP_W]),
      .vertex_count (vc_ff),
      .emit_go      (emit_go),
      .emit_done    (emit_done),
      .n_out        (n_cur),
      .cut_out      (cut)
   );

   apf_emit #(.MAX_VERTICES(MAX_VERTICES)) u_emit (
      .clock      (clock),
      .reset      (reset),
      .go         (emit_go),
      .n_in       (n_cur),
      .cut        (cut),
      .done       (emit_done),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_vertex (rsp_vertex),
      .rsp_found  (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - CV_W)'(0), rsp_vertex};

endmodule
